/* sv/b2da_pkg.sv */
`default_nettype none

package b2da_pkg;

   localparam int VALUE_W = 31;
   localparam int CHAR_W  = 6;
   localparam int DIGIT_W = 4;
   localparam int QUOT_W  = 28;
   localparam int PROD_W  = 64;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [31:0]       RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                RECIP_SHIFT = 35;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_REM,
      ST_EMIT
   } b2da_state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic step;
      logic emit;
   } b2da_cmd_type;

   typedef struct packed {
      logic quot_zero;
      logic count_full;
      logic idx_zero;
      logic out_free;
   } b2da_status_type;

endpackage

`default_nettype wire

/* sv/b2da_ctrl.sv */
`default_nettype none

module b2da_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  b2da_pkg::b2da_status_type status,
   output b2da_pkg::b2da_cmd_type    cmd
);
   import b2da_pkg::*;

   b2da_state_type state_ff;
   b2da_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_REM;
         end
         ST_REM: begin
            cmd.step = 1'b1;
            if (status.quot_zero || status.count_full) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.idx_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/b2da_datapath.sv */
`default_nettype none

module b2da_datapath #(
   parameter int MAX_DIGITS = 10
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire [b2da_pkg::VALUE_W-1:0]         req_value,
   input  b2da_pkg::b2da_cmd_type              cmd,
   output b2da_pkg::b2da_status_type           status,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [b2da_pkg::CHAR_W-1:0]         rsp_digit_char,
   output logic                                rsp_last
);
   import b2da_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [VALUE_W-1:0] value_ff;
   logic [QUOT_W-1:0]  quot_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [DIGIT_W-1:0] digit_buf_ff [MAX_DIGITS];
   logic               out_valid_ff;
   logic [CHAR_W-1:0]  out_char_ff;
   logic               out_last_ff;

   logic [PROD_W-1:0]  prod;
   logic [VALUE_W-1:0] ten_quot;
   logic [VALUE_W-1:0] diff;

   assign prod     = PROD_W'(value_ff) * PROD_W'(RECIP_TEN);
   assign ten_quot = (VALUE_W'(quot_ff) << 3) + (VALUE_W'(quot_ff) << 1);
   assign diff     = value_ff - ten_quot;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_value;
      end else if (cmd.step) begin
         value_ff <= VALUE_W'(quot_ff);
      end
      if (cmd.mul) begin
         quot_ff <= prod[RECIP_SHIFT +: QUOT_W];
      end
      if (cmd.step) begin
         digit_buf_ff[cnt_ff[IDX_W-1:0]] <= diff[DIGIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         idx_ff <= cnt_ff[IDX_W-1:0];
      end else if (cmd.emit) begin
         idx_ff <= idx_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         out_char_ff <= ASCII_ZERO + CHAR_W'(digit_buf_ff[idx_ff]);
         out_last_ff <= (idx_ff == '0);
      end
   end

   assign status.quot_zero  = (quot_ff == '0);
   assign status.count_full = (cnt_ff == CNT_W'(MAX_DIGITS - 1));
   assign status.idx_zero   = (idx_ff == '0);
   assign status.out_free   = !out_valid_ff || !rsp_stall;

   assign rsp_valid      = out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last       = out_last_ff;

endmodule

`default_nettype wire

/* sv/binary_to_decimal_ascii_core.sv */
// channel   ports                                        direction
// req       req_valid, req_stall, req_value[30:0]        in
// rsp       rsp_valid, rsp_stall, rsp_digit_char[5:0],   out
//           rsp_last
//
// Each digit is worked as a reciprocal multiply, then a remainder and
// buffer write; once all digits are in the buffer they are sent one by one.
// One number is worked at a time; the next beat is taken once the last
// digit sits in the output register. Reset is synchronous and clears the
// controller, the digit count and index, and the output valid.
// rsp_stall holds the output register.
`default_nettype none

module binary_to_decimal_ascii_core #(
   parameter int MAX_DIGITS = 10
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire [b2da_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [b2da_pkg::CHAR_W-1:0]  rsp_digit_char,
   output logic                         rsp_last
);
   import b2da_pkg::*;

   b2da_cmd_type    cmd;
   b2da_status_type status;

   b2da_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   b2da_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

/* sv/b2da_checker.sv */
`default_nettype none

module b2da_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_stall,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire [5:0] rsp_digit_char,
   input wire       rsp_last
);

   a_reset_clears_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= 6'd48 && rsp_digit_char <= 6'd57))
      else $error("character outside digit range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("beat taken while previous number in work");

   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("beat taken before run finished");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last)))
      else $error("stalled output changed");

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_checker (.*);

`default_nettype wire
